### hdl/vsd_pkg.sv
// Shared types and constants for the LEB128 varint stream decoder.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps

package vsd_pkg;

	// Byte layout of an encoded varint
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DIGIT_W    = 7;
	localparam int unsigned CONT_BIT   = 7;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned SHIFT_W    = 6;

	localparam logic [BYTE_W-1:0] LAST_RANGE_MASK = 8'h7e;
	localparam logic [LEN_W-1:0]  MAX_BYTES       = 4'd10;
	localparam logic [LEN_W-1:0]  LAST_POS        = 4'd9;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TRUNCATED = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	// One input transaction
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              input_ends;
	} in_item_t;

	// One result transaction
	typedef struct packed {
		logic [VALUE_W-1:0] decoded_value;
		status_t            status;
		logic [LEN_W-1:0]   encoded_length;
		logic               is_canonical;
	} out_item_t;

endpackage

### hdl/vsd_stream_if.sv
// Valid/ready stream channel carrying one payload struct per transaction.
// The payload type is a parameter; no dependencies.
`timescale 1ns / 1ps

interface vsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hdl/varint_stream_decoder_top.sv
// Top level of the unsigned LEB128 varint stream decoder.
// Depends on vsd_pkg (types, constants) and vsd_stream_if (channels).
`timescale 1ns / 1ps
//
// Channel        Direction  Payload                                             Handshake
// byte_stream    sink       data_byte[7:0], input_ends                          valid/ready
// result_stream  source     decoded_value[63:0], status[1:0], encoded_length[3:0],
//                           is_canonical                                        valid/ready
//
// One byte per cycle while the result side is not stalled: a byte is captured in the input register,
// is decoded by a 64-bit shift-and-OR into the accumulator, and its result (if any)
// is then registered in the output register, where it is held until taken.
// arst_n clears the accumulator, byte count and both valid flags.
// A stalled result holds the input register; bytes that end no varint still need
// the output register free for their cycle to advance.

module varint_stream_decoder_top
	import vsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	vsd_stream_if.sink           byte_stream,
	vsd_stream_if.source         result_stream
);

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              ends_s1;

	// Decoder state
	logic [VALUE_W-1:0] acc_q;
	logic [LEN_W-1:0]   cnt_q;

	// Output register
	logic      res_valid_q;
	out_item_t res_q;

	// Decode signals
	logic               advance;
	logic [SHIFT_W:0]   shift_wide;
	logic [SHIFT_W-1:0] shift_amt;
	logic [VALUE_W-1:0] digit_bits;
	logic [VALUE_W-1:0] merged;
	logic               at_last;
	logic               emit;
	out_item_t          res_d;

	// Advance the input stage when the output register is free or draining
	assign advance           = valid_s1 && (!res_valid_q || result_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance;

	// Place the 7 value bits at position 7 * count
	assign shift_wide = {cnt_q, 3'b000} - {3'b000, cnt_q};
	assign shift_amt  = shift_wide[SHIFT_W-1:0];
	assign digit_bits = {{(VALUE_W-DIGIT_W){1'b0}}, data_s1[DIGIT_W-1:0]} << shift_amt;
	assign merged     = acc_q | digit_bits;
	assign at_last    = (cnt_q == LAST_POS);

	// Classify the byte and build the result
	always_comb begin
		emit                 = 1'b0;
		res_d.decoded_value  = '0;
		res_d.status         = STATUS_OK;
		res_d.encoded_length = '0;
		res_d.is_canonical   = 1'b0;
		if (ends_s1) begin
			emit                 = 1'b1;
			res_d.status         = STATUS_TRUNCATED;
			res_d.encoded_length = cnt_q;
		end else if (at_last && ((data_s1 & LAST_RANGE_MASK) != '0)) begin
			emit                 = 1'b1;
			res_d.status         = STATUS_OVERFLOW;
			res_d.encoded_length = MAX_BYTES;
		end else if (!data_s1[CONT_BIT]) begin
			emit                 = 1'b1;
			res_d.decoded_value  = merged;
			res_d.encoded_length = cnt_q + 4'd1;
			res_d.is_canonical   = (cnt_q == '0) || (data_s1[DIGIT_W-1:0] != '0);
		end else if (at_last) begin
			emit                 = 1'b1;
			res_d.status         = STATUS_OVERFLOW;
			res_d.encoded_length = MAX_BYTES;
		end
	end

	// Capture the next byte transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			data_s1 <= byte_stream.payload.data_byte;
			ends_s1 <= byte_stream.payload.input_ends;
		end
	end

	// Update accumulator and count; restart after any result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			if (emit) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= merged;
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (result_stream.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign result_stream.valid   = res_valid_q;
	assign result_stream.payload = res_q;

`ifndef NO_ASSERTIONS
	// Byte count never passes the tenth position
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_POS)
		else $error("byte count out of range");

	// Failed results carry a zero value and no canonical flag
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status != STATUS_OK)) |->
			(res_q.decoded_value == '0 && !res_q.is_canonical))
		else $error("non-ok result carries value or canonical flag");

	// An ok result spans one to ten bytes
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status == STATUS_OK)) |->
			(res_q.encoded_length != '0 && res_q.encoded_length <= MAX_BYTES))
		else $error("ok result length out of range");

	// Any emitted result restarts the varint on the next cycle
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (cnt_q == '0 && acc_q == '0))
		else $error("state not cleared after result");
`endif

endmodule
